[src/assert_macros.svh]
// Assertion macros for the RTL of the button click event detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every rising edge outside reset.
`define BCD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Check that a condition never holds at a rising edge outside reset.
`define BCD_NEVER(label, clk, rst, cond) \
   `BCD_ASSERT(label, clk, rst, !(cond))
`else
`define BCD_ASSERT(label, clk, rst, prop)
`define BCD_NEVER(label, clk, rst, cond)
`endif
`endif

[src/bcd_pkg.sv]
// Types and constants shared by the button click event detector modules.
package bcd_pkg;

   // Event codes.
   localparam logic [2:0] EV_NONE       = 3'd0;
   localparam logic [2:0] EV_DOWN       = 3'd1;
   localparam logic [2:0] EV_UP         = 3'd2;
   localparam logic [2:0] EV_REPEAT     = 3'd3;
   localparam logic [2:0] EV_SINGLE     = 3'd4;
   localparam logic [2:0] EV_DOUBLE     = 3'd5;
   localparam logic [2:0] EV_LONG_START = 3'd6;
   localparam logic [2:0] EV_LONG_HOLD  = 3'd7;

   // Configuration register indexes.
   localparam logic [1:0] CSR_ACTIVE_LEVEL   = 2'd0;
   localparam logic [1:0] CSR_DEBOUNCE_TICKS = 2'd1;
   localparam logic [1:0] CSR_SHORT_TICKS    = 2'd2;
   localparam logic [1:0] CSR_LONG_TICKS     = 2'd3;

   localparam int CSR_DATA_W = 16;

   // Everything one tick produces: up to three events plus shared fields.
   typedef struct packed {
      logic [2:0] ev0;
      logic [2:0] ev1;
      logic [2:0] ev2;
      logic [1:0] last_idx;     // index of the final beat, 0..2
      logic [2:0] latched;
      logic [3:0] repeat_cnt;
   } tick_rec_type;

endpackage

[src/bcd_fifo.sv]
// Small queue of tick records between the classifier and the beat sequencer.
module bcd_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bcd_pkg::tick_rec_type push_rec,
   input  logic                  pop,
   output bcd_pkg::tick_rec_type head_rec,
   output logic                  full,
   output logic                  empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   bcd_pkg::tick_rec_type mem_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign head_rec = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

[src/bcd_front.sv]
// Debounce filter, click state machine and configuration registers.
module bcd_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [1:0]                       csr_index,
   input  logic [bcd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             take,
   input  logic                             sample,
   output bcd_pkg::tick_rec_type            rec
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PRESS = 3'd1;
   localparam logic [2:0] ST_WAIT  = 3'd2;
   localparam logic [2:0] ST_AGAIN = 3'd3;
   localparam logic [2:0] ST_LONG  = 3'd5;

   logic        active_ff;
   logic [2:0]  deb_ticks_ff;
   logic [15:0] short_ff;
   logic [15:0] long_ff;

   logic [2:0]  state_ff, state_in;
   logic        filt_ff, filt_in;
   logic [2:0]  deb_cnt_ff, deb_cnt_in;
   logic [15:0] tick_ff, tick_in;
   logic [3:0]  rep_ff, rep_in;
   logic [2:0]  cur_ev_ff, cur_ev_in;

   logic [2:0]  deb_inc;
   logic        pressed;

   always_comb begin
      tick_in    = (state_ff != ST_IDLE) ? tick_ff + 16'd1 : tick_ff;
      deb_inc    = deb_cnt_ff + 3'd1;
      filt_in    = filt_ff;
      deb_cnt_in = '0;
      if (sample != filt_ff) begin
         if (deb_inc >= deb_ticks_ff) begin
            filt_in = sample;
         end else begin
            deb_cnt_in = deb_inc;
         end
      end
      pressed = (filt_in == active_ff);

      state_in     = state_ff;
      rep_in       = rep_ff;
      cur_ev_in    = cur_ev_ff;
      rec.ev0      = bcd_pkg::EV_NONE;
      rec.ev1      = bcd_pkg::EV_NONE;
      rec.ev2      = bcd_pkg::EV_NONE;
      rec.last_idx = 2'd0;

      unique case (state_ff)
         ST_IDLE: begin
            if (pressed) begin
               cur_ev_in = bcd_pkg::EV_DOWN;
               rec.ev0   = bcd_pkg::EV_DOWN;
               tick_in   = '0;
               rep_in    = 4'd1;
               state_in  = ST_PRESS;
            end else begin
               cur_ev_in = bcd_pkg::EV_NONE;
            end
         end
         ST_PRESS: begin
            if (!pressed) begin
               cur_ev_in = bcd_pkg::EV_UP;
               rec.ev0   = bcd_pkg::EV_UP;
               tick_in   = '0;
               state_in  = ST_WAIT;
            end else if (tick_in > long_ff) begin
               cur_ev_in = bcd_pkg::EV_LONG_START;
               rec.ev0   = bcd_pkg::EV_LONG_START;
               state_in  = ST_LONG;
            end
         end
         ST_WAIT: begin
            if (pressed) begin
               cur_ev_in = bcd_pkg::EV_DOWN;
               rec.ev0   = bcd_pkg::EV_DOWN;
               rep_in    = rep_ff + 4'd1;
               if (rep_in == 4'd2) begin
                  rec.ev1      = bcd_pkg::EV_DOUBLE;
                  rec.ev2      = bcd_pkg::EV_REPEAT;
                  rec.last_idx = 2'd2;
               end else begin
                  rec.ev1      = bcd_pkg::EV_REPEAT;
                  rec.last_idx = 2'd1;
               end
               tick_in  = '0;
               state_in = ST_AGAIN;
            end else if (tick_in > short_ff) begin
               if (rep_ff == 4'd1) begin
                  cur_ev_in = bcd_pkg::EV_SINGLE;
                  rec.ev0   = bcd_pkg::EV_SINGLE;
               end else if (rep_ff == 4'd2) begin
                  cur_ev_in = bcd_pkg::EV_DOUBLE;
               end
               state_in = ST_IDLE;
            end
         end
         ST_AGAIN: begin
            if (!pressed) begin
               cur_ev_in = bcd_pkg::EV_UP;
               rec.ev0   = bcd_pkg::EV_UP;
               if (tick_in < short_ff) begin
                  tick_in  = '0;
                  state_in = ST_WAIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_LONG: begin
            if (pressed) begin
               cur_ev_in = bcd_pkg::EV_LONG_HOLD;
               rec.ev0   = bcd_pkg::EV_LONG_HOLD;
            end else begin
               cur_ev_in = bcd_pkg::EV_UP;
               rec.ev0   = bcd_pkg::EV_UP;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            // Unreachable codes: the state holds; only the tick counter and the debounce filter move.
         end
      endcase

      rec.latched    = cur_ev_in;
      rec.repeat_cnt = rep_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         deb_ticks_ff <= 3'd3;
         short_ff     <= 16'd60;
         long_ff      <= 16'd200;
         state_ff     <= ST_IDLE;
         filt_ff      <= 1'b1;
         deb_cnt_ff   <= '0;
         tick_ff      <= '0;
         rep_ff       <= '0;
         cur_ev_ff    <= bcd_pkg::EV_NONE;
      end else if (csr_we) begin
         unique case (csr_index)
            bcd_pkg::CSR_ACTIVE_LEVEL: begin
               active_ff  <= csr_wdata[0];
               filt_ff    <= ~csr_wdata[0];
               deb_cnt_ff <= '0;
            end
            bcd_pkg::CSR_DEBOUNCE_TICKS: deb_ticks_ff <= csr_wdata[2:0];
            bcd_pkg::CSR_SHORT_TICKS:    short_ff     <= csr_wdata[15:0];
            bcd_pkg::CSR_LONG_TICKS:     long_ff      <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end else if (take) begin
         state_ff   <= state_in;
         filt_ff    <= filt_in;
         deb_cnt_ff <= deb_cnt_in;
         tick_ff    <= tick_in;
         rep_ff     <= rep_in;
         cur_ev_ff  <= cur_ev_in;
      end
   end

endmodule

[src/bcd_back.sv]
// Beat sequencer: splits one queued tick record into its result beats.
module bcd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  bcd_pkg::tick_rec_type head_rec,
   input  logic                  q_empty,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [2:0]            rsp_event_code,
   output logic [2:0]            rsp_latched_event,
   output logic [3:0]            rsp_repeat_count,
   output logic                  rsp_last
);

   logic [1:0] beat_ff, beat_in;
   logic       beat_done;

   assign rsp_empty         = q_empty;
   assign rsp_latched_event = head_rec.latched;
   assign rsp_repeat_count  = head_rec.repeat_cnt;
   assign rsp_last          = (beat_ff == head_rec.last_idx);
   assign beat_done         = rsp_pop & ~q_empty;
   assign q_pop             = beat_done & rsp_last;

   always_comb begin
      unique case (beat_ff)
         2'd0:    rsp_event_code = head_rec.ev0;
         2'd1:    rsp_event_code = head_rec.ev1;
         default: rsp_event_code = head_rec.ev2;
      endcase
      beat_in = beat_ff;
      if (beat_done) begin
         beat_in = rsp_last ? 2'd0 : beat_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= '0;
      end else begin
         beat_ff <= beat_in;
      end
   end

endmodule

[src/button_click_event_detector_unit.sv]
// A sample's record is written into the queue when its push is taken; its beats appear at the queue head.
// Samples are taken one per cycle while the queue is not full; a tick yields one to three beats, drained one per pop.
// Rate is set by the rsp side: the sequencer emits one beat per cycle from the queue head while rsp_pop is high.
// req_full rises only when the record queue (DEPTH ticks) is full.
// Reset (synchronous) loads register defaults, idles the machine and empties the queue.
`include "assert_macros.svh"
module button_click_event_detector_unit #(
   parameter int DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   // configuration write port
   input  logic                           csr_we,
   input  logic [1:0]                     csr_index,
   input  logic [bcd_pkg::CSR_DATA_W-1:0] csr_wdata,
   // sample input, queue style
   input  logic                           req_push,
   output logic                           req_full,
   input  logic                           req_sample,
   // result output, queue style
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [2:0]                     rsp_event_code,
   output logic [2:0]                     rsp_latched_event,
   output logic [3:0]                     rsp_repeat_count,
   output logic                           rsp_last
);

   bcd_pkg::tick_rec_type rec;       // record classified this cycle
   bcd_pkg::tick_rec_type head_rec;  // oldest queued record
   logic                  take;
   logic                  q_full;
   logic                  q_empty;
   logic                  q_pop;
   logic                  mid_beat;       // a non-final beat is on the rsp ports
   logic                  mid_burst_pop;  // a non-final beat is taken
   logic [6:0]            rsp_shared;     // fields common to all beats of a tick

   // Accept a sample whenever the queue has room; the front updates its state then unless csr_we is high.
   assign req_full = q_full;
   assign take     = req_push & ~q_full;

   // Front: debounce, run the click machine, build one record per tick.
   bcd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .take      (take),
      .sample    (req_sample),
      .rec       (rec)
   );

   // Queue: decouple sample intake from beat delivery.
   bcd_fifo #(
      .DEPTH (DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (take),
      .push_rec (rec),
      .pop      (q_pop),
      .head_rec (head_rec),
      .full     (q_full),
      .empty    (q_empty)
   );

   // Back: walk the head record beat by beat, release it after its last beat.
   bcd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_rec          (head_rec),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_event_code    (rsp_event_code),
      .rsp_latched_event (rsp_latched_event),
      .rsp_repeat_count  (rsp_repeat_count),
      .rsp_last          (rsp_last)
   );

   assign mid_beat      = ~rsp_empty & ~rsp_last;
   assign mid_burst_pop = rsp_pop & mid_beat;
   assign rsp_shared    = {rsp_latched_event, rsp_repeat_count};

   // Only the final beat of a tick may carry no event.
   `BCD_NEVER(a_nonlast_has_event, clock, reset, mid_beat && rsp_event_code == bcd_pkg::EV_NONE)
   // A tick's later beats follow at once.
   `BCD_ASSERT(a_burst_continues, clock, reset, mid_burst_pop |=> !rsp_empty)
   // Shared fields hold across the beats of one tick.
   `BCD_ASSERT(a_burst_shared, clock, reset, mid_burst_pop |=> $stable(rsp_shared))

endmodule
